// File: rtl/core/utt_pkg.sv
// Shared types, constants and the UTF-8 byte builder for the UTF-16 to UTF-8 transcoder.
package utt_pkg;

  localparam int UTT_QUEUE_DEPTH = 4;

  // Error codes carried on each result item.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_INCOMPLETE = 2'd1;
  localparam logic [1:0] ERR_DAMAGED    = 2'd2;
  localparam logic [1:0] ERR_MISSING    = 2'd3;

  // One unit of work for the back end: a code point and how many bytes it takes.
  // Error jobs carry a zero code point and a single byte.
  typedef struct packed {
    logic [20:0] code_point;
    logic [1:0]  bytes_m1;
    logic [1:0]  err;
    logic        str_end;
  } utt_job_t;

  // Byte number idx of the UTF-8 encoding of code_point, which is bytes_m1 + 1 bytes long.
  function automatic logic [7:0] utf8_byte(input logic [20:0] code_point,
                                           input logic [1:0]  bytes_m1,
                                           input logic [1:0]  idx);
    logic [7:0] b;
    b = 8'h00;
    unique case ({bytes_m1, idx})
      4'b00_00: b = code_point[7:0];
      4'b01_00: b = {3'b110, code_point[10:6]};
      4'b01_01: b = {2'b10, code_point[5:0]};
      4'b10_00: b = {4'b1110, code_point[15:12]};
      4'b10_01: b = {2'b10, code_point[11:6]};
      4'b10_10: b = {2'b10, code_point[5:0]};
      4'b11_00: b = {5'b11110, code_point[20:18]};
      4'b11_01: b = {2'b10, code_point[17:12]};
      4'b11_10: b = {2'b10, code_point[11:6]};
      4'b11_11: b = {2'b10, code_point[5:0]};
      default:  b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/utt_front.sv
// Front end: accepts code units, tracks surrogate pairs and string failure, and queues jobs.
module utt_front import utt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [15:0] code_unit,
  input  logic        end_of_string,
  output logic        push,
  output utt_job_t    job
);

  logic [9:0] pending_high_bits;
  logic [9:0] pending_high_bits_next;
  logic       pending_valid;
  logic       pending_valid_next;
  logic       string_failed;
  logic       string_failed_next;
  logic       is_high;
  logic       is_low;
  logic       make_job;

  assign is_high = (code_unit[15:10] == 6'b110110);
  assign is_low  = (code_unit[15:10] == 6'b110111);

  always_comb begin
    pending_high_bits_next = pending_high_bits;
    pending_valid_next     = pending_valid;
    string_failed_next     = string_failed;
    make_job               = 1'b0;
    job.code_point         = 21'd0;
    job.bytes_m1           = 2'd0;
    job.err                = ERR_NONE;
    job.str_end            = 1'b1;
    if (string_failed) begin
      // The rest of a failed string is dropped; its end unit clears the failure.
      if (end_of_string) begin
        string_failed_next = 1'b0;
      end
    end else if (pending_valid) begin
      make_job               = 1'b1;
      pending_valid_next     = 1'b0;
      pending_high_bits_next = 10'd0;
      if (!is_low) begin
        job.err            = ERR_DAMAGED;
        string_failed_next = !end_of_string;
      end else begin
        job.code_point = 21'h10000 + {1'b0, pending_high_bits, code_unit[9:0]};
        job.bytes_m1   = 2'd3;
        job.str_end    = end_of_string;
      end
    end else if (is_high) begin
      if (end_of_string) begin
        make_job = 1'b1;
        job.err  = ERR_INCOMPLETE;
      end else begin
        pending_valid_next     = 1'b1;
        pending_high_bits_next = code_unit[9:0];
      end
    end else if (is_low) begin
      make_job           = 1'b1;
      job.err            = ERR_MISSING;
      string_failed_next = !end_of_string;
    end else begin
      make_job       = 1'b1;
      job.code_point = {5'd0, code_unit};
      job.str_end    = end_of_string;
      if (code_unit[15:7] == 9'd0) begin
        job.bytes_m1 = 2'd0;
      end else if (code_unit[15:11] == 5'd0) begin
        job.bytes_m1 = 2'd1;
      end else begin
        job.bytes_m1 = 2'd2;
      end
    end
  end

  assign push = accept && make_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high_bits <= 10'd0;
      pending_valid     <= 1'b0;
      string_failed     <= 1'b0;
    end else if (accept) begin
      pending_high_bits <= pending_high_bits_next;
      pending_valid     <= pending_valid_next;
      string_failed     <= string_failed_next;
    end
  end

endmodule

// File: rtl/core/utt_queue.sv
// Short job queue between the front end and the back end.
module utt_queue import utt_pkg::*; #(
  parameter int DEPTH = UTT_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  utt_job_t push_job,
  input  logic     pop,
  output utt_job_t head,
  output logic     empty,
  output logic     full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utt_job_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign empty = (count == CW'(0));
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/utt_back.sv
// Back end: walks jobs one byte per unstalled cycle into a registered output.
module utt_back import utt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  utt_job_t   head,
  input  logic       empty,
  output logic       pop,
  output logic       byte_valid,
  input  logic       byte_stall,
  output logic [7:0] out_byte,
  output logic [1:0] error_code,
  output logic       last_in_run,
  output logic       string_end
);

  logic [1:0] idx;
  logic       advance;
  logic       is_last;

  assign advance = !byte_valid || !byte_stall;
  assign is_last = (idx == head.bytes_m1);
  assign pop     = advance && !empty && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      idx        <= 2'd0;
    end else if (advance) begin
      byte_valid <= !empty;
      if (!empty) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !empty) begin
      out_byte    <= utf8_byte(head.code_point, head.bytes_m1, idx);
      error_code  <= head.err;
      last_in_run <= is_last;
      string_end  <= is_last && head.str_end;
    end
  end

endmodule

// File: rtl/core/utf16_to_utf8_transcoder.sv
// Top level of the UTF-16 to UTF-8 transcoder: front end, job queue and byte emitter.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+------------------------------------------
//   unit    | in        | unit_valid / unit_stall   | code_unit, end_of_string
//   byte    | out       | byte_valid / byte_stall   | out_byte, error_code, last_in_run,
//           |           |                           | string_end
//
// A code unit is taken in every cycle while the job queue has room; the front end
// classifies it in the cycle it arrives and queues at most one job.
// The back end sends one byte per cycle while byte_stall is low, and a unit yields one to
// four bytes (units that yield nothing send none); the output byte port sets the throughput.
// From accepted unit to first byte, a job passes through the queue and the output register.
// A stalled output holds its byte; the queue absorbs up to QUEUE_DEPTH jobs before
// unit_stall rises. Reset is synchronous and clears the surrogate state and the queue.
module utf16_to_utf8_transcoder import utt_pkg::*; #(
  parameter int QUEUE_DEPTH = UTT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        unit_valid,
  output logic        unit_stall,
  input  logic [15:0] code_unit,
  input  logic        end_of_string,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  error_code,
  output logic        last_in_run,
  output logic        string_end
);

  utt_job_t new_job;
  utt_job_t head_job;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;
  logic     unit_accept;

  // The queue being full is the only reason to hold off a code unit.
  assign unit_stall  = q_full;
  assign unit_accept = unit_valid && !unit_stall;

  utt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (unit_accept),
    .code_unit     (code_unit),
    .end_of_string (end_of_string),
    .push          (push),
    .job           (new_job)
  );

  utt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (new_job),
    .pop      (pop),
    .head     (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  utt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_job),
    .empty       (q_empty),
    .pop         (pop),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .out_byte    (out_byte),
    .error_code  (error_code),
    .last_in_run (last_in_run),
    .string_end  (string_end)
  );

  // An error item is a single zero byte that ends both its run and its string.
  a_error_item: assert property (@(posedge clk) disable iff (rst)
    byte_valid && (error_code != ERR_NONE) |->
      (out_byte == 8'h00) && last_in_run && string_end)
    else $error("error item is not a lone terminating zero byte");

  // The end of a string always falls on the last byte of a run.
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    byte_valid && string_end |-> last_in_run)
    else $error("string end flagged before the last byte of a run");

  // The front end never queues a job into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("job pushed into a full queue");

  // Nothing is taken from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !pop)
    else $error("job popped from an empty queue");

endmodule
